// ===== src/mmc_pkg.sv =====
// Package: shared types and constants of the modulation matrix combiner.
package mmc_pkg;

	localparam int MaxRoutes  = 16;
	localparam int NumSources = 16;
	localparam int IdxW       = $clog2(MaxRoutes);
	localparam int CntW       = $clog2(MaxRoutes + 1);
	localparam int SrcW       = 4;
	localparam int SrcIdxW    = (NumSources > 1) ? $clog2(NumSources) : 1;
	localparam int TgtW       = 6;
	localparam int IdW        = 16;
	localparam int ValW       = 16;
	localparam int AccW       = 24;

	localparam logic signed [AccW-1:0] OneQ12 = 24'sd4096;
	localparam logic signed [AccW-1:0] SatHi  = 24'sh7FFFFF;
	localparam logic signed [AccW-1:0] SatLo  = 24'sh800000;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SOURCE = 2'd2,
		OP_UPDATE = 2'd3
	} op_t;

	typedef struct packed {
		logic [IdW-1:0]         id;
		logic [TgtW-1:0]        target;
		logic [SrcW-1:0]        source;
		logic signed [ValW-1:0] depth;
		logic signed [ValW-1:0] bias;
		logic                   mult;
		logic                   en;
	} route_t;

	// Control broadcast from the sequencer to every cell
	typedef struct packed {
		logic             shift_ins;   // insert: shift right from ins_pos
		logic [IdxW-1:0]  ins_pos;
		logic             compact;     // remove step: shift left from del_pos
		logic [IdxW-1:0]  del_pos;
		logic             rotate;      // update walk: rotate left by one
	} cell_ctl_t;

	function automatic logic signed [AccW-1:0] sat24(input logic signed [47:0] x);
		if (x > 48'sd8388607)
			return SatHi;
		if (x < -48'sd8388608)
			return SatLo;
		return x[AccW-1:0];
	endfunction

endpackage

// ===== src/mmc_cell.sv =====
// One table cell: holds a route and hands it to a neighbour on shift or rotate.
module mmc_cell
	import mmc_pkg::*;
(
	input  logic                clk,
	input  logic [IdxW-1:0]     pos,
	input  cell_ctl_t           ctl,
	input  route_t              new_route,
	input  route_t              left_route,
	input  route_t              right_route,
	input  route_t              head_route,
	input  logic                is_tail,
	output route_t              route
);

	route_t route_q;

	always_ff @(posedge clk) begin
		if (ctl.shift_ins) begin
			if (pos == ctl.ins_pos)
				route_q <= new_route;
			else if (pos > ctl.ins_pos)
				route_q <= left_route;
		end else if (ctl.compact) begin
			if (pos >= ctl.del_pos)
				route_q <= right_route;
		end else if (ctl.rotate) begin
			route_q <= is_tail ? head_route : right_route;
		end
	end

	assign route = route_q;

endmodule

// ===== src/mmc_chain.sv =====
// Row of route cells forming the ordered route table.
module mmc_chain
	import mmc_pkg::*;
(
	input  logic                clk,
	input  cell_ctl_t           ctl,
	input  route_t              new_route,
	input  logic [IdxW-1:0]     tail_pos,
	output route_t              routes [MaxRoutes]
);

	for (genvar g = 0; g < MaxRoutes; g++) begin : g_cell
		mmc_cell u_cell (
			.clk         (clk),
			.pos         (IdxW'(g)),
			.ctl         (ctl),
			.new_route   (new_route),
			.left_route  (routes[(g == 0) ? 0 : g - 1]),
			.right_route (routes[(g == MaxRoutes - 1) ? g : g + 1]),
			.head_route  (routes[0]),
			.is_tail     (tail_pos == IdxW'(g)),
			.route       (routes[g])
		);
	end

endmodule

// ===== src/modulation_matrix_combiner_unit.sv =====
// Top level: modulation matrix combiner with a route table held in a cell chain.
//
//  channel | signals                                         | handshake
//  --------+-------------------------------------------------+-----------------------
//  in      | op route_* bindings_present remove_id source_*   | start & !busy
//  out     | kind status assigned_id out_target mod_value last | strobe, one cycle
//
// Add: search at acceptance, busy during the insert state, acknowledge in the cycle after it.
// A rejected add is acknowledged in the cycle after acceptance with no busy cycle.
// Remove: scans the table entry by entry, compacting on a match, then sets the new count.
// Update: the chain rotates through all 16 cells, then the emit state drains the pipeline.
// Set source: written at acceptance without going busy. Reset clears the count, next id and source values.
// Results cannot be stalled; busy holds off new items while work is running.
module modulation_matrix_combiner_unit
	import mmc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             op,
	input  logic [TgtW-1:0]        route_target,
	input  logic [SrcW-1:0]        route_source,
	input  logic signed [ValW-1:0] route_depth,
	input  logic signed [ValW-1:0] route_bias,
	input  logic                   route_multiplies,
	input  logic                   route_enabled,
	input  logic                   bindings_present,
	input  logic [IdW-1:0]         remove_id,
	input  logic signed [ValW-1:0] source_sample,
	output logic                   strobe,
	output logic                   kind,
	output logic                   status,
	output logic [IdW-1:0]         assigned_id,
	output logic [TgtW-1:0]        out_target,
	output logic signed [AccW-1:0] mod_value,
	output logic                   last
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_INSERT = 5'b00010,
		ST_REMOVE = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [CntW-1:0]        count_q;
	logic [IdW-1:0]         next_id_q;
	logic signed [ValW-1:0] src_q [NumSources];
	route_t                 new_q;
	logic [IdxW-1:0]        ins_q;
	logic [IdW-1:0]         rid_q;
	logic [CntW-1:0]        step_q;
	logic [CntW-1:0]        wr_q;
	logic signed [AccW-1:0] acc_q;
	logic                   first_q;
	logic signed [31:0]     prod_q;
	logic signed [ValW-1:0] bias_q;
	logic                   pmult_q;
	logic                   pen_q;
	logic                   pfirst_q;
	logic                   pend_q;
	logic                   plast_q;
	logic                   pvalid_q;
	logic [TgtW-1:0]        ptgt_q;

	route_t                 routes [MaxRoutes];
	cell_ctl_t              ctl;
	logic [CntW-1:0]        find_pos;
	logic                   accept;
	logic [IdxW-1:0]        tail_pos;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		find_pos = count_q;
		for (int i = MaxRoutes - 1; i >= 0; i--)
			if (CntW'(i) < count_q && routes[i].target == route_target)
				find_pos = CntW'(i);
	end

	// Rotate uses the full chain so the table returns to its order after a pass
	assign tail_pos = IdxW'(MaxRoutes - 1);

	always_comb begin
		ctl           = '0;
		ctl.ins_pos   = ins_q;
		ctl.del_pos   = wr_q[IdxW-1:0];
		ctl.shift_ins = (state_q == ST_INSERT);
		ctl.compact   = (state_q == ST_REMOVE) && step_q < count_q
			&& routes[wr_q[IdxW-1:0]].id == rid_q;
		ctl.rotate    = (state_q == ST_UPDATE);
	end

	mmc_chain u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.new_route (new_q),
		.tail_pos  (tail_pos),
		.routes    (routes)
	);

	logic signed [ValW-1:0] head_src;
	logic signed [47:0]     v_full;
	logic signed [47:0]     acc_start;
	logic signed [AccW-1:0] acc_next;
	logic signed [47:0]     mprod;

	assign head_src = (int'(routes[0].source) < NumSources)
		? src_q[routes[0].source[SrcIdxW-1:0]] : '0;

	always_comb begin
		v_full    = 48'(prod_q >>> 15) + 48'(bias_q);
		acc_start = pfirst_q ? (pmult_q ? 48'(OneQ12) : 48'sd0) : 48'(acc_q);
		mprod     = $signed(acc_start[AccW-1:0]) * $signed(v_full[17:0]);
		if (!pen_q)
			acc_next = acc_start[AccW-1:0];
		else if (pmult_q)
			acc_next = sat24(mprod >>> 12);
		else
			acc_next = sat24(acc_start + v_full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			next_id_q <= '0;
			for (int i = 0; i < NumSources; i++)
				src_q[i] <= '0;
			strobe    <= 1'b0;
			pvalid_q  <= 1'b0;
			first_q   <= 1'b1;
			step_q    <= '0;
			wr_q      <= '0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op_t'(op))
							OP_ADD: begin
								kind <= 1'b0; out_target <= '0; mod_value <= '0; last <= 1'b0;
								if (!bindings_present || count_q >= CntW'(MaxRoutes)) begin
									status <= 1'b1; assigned_id <= '0; strobe <= 1'b1;
								end else begin
									status      <= 1'b0;
									assigned_id <= next_id_q;
									new_q       <= '{next_id_q, route_target, route_source,
										route_depth, route_bias, route_multiplies, route_enabled};
									ins_q       <= find_pos[IdxW-1:0];
									state_q     <= ST_INSERT;
								end
							end
							OP_REMOVE: begin
								rid_q   <= remove_id;
								step_q  <= '0;
								wr_q    <= '0;
								state_q <= ST_REMOVE;
							end
							OP_SOURCE: begin
								if (int'(route_source) < NumSources)
									src_q[route_source[SrcIdxW-1:0]] <= source_sample;
							end
							OP_UPDATE: begin
								if (count_q != '0) begin
									step_q   <= '0;
									first_q  <= 1'b1;
									pvalid_q <= 1'b0;
									state_q  <= ST_UPDATE;
								end
							end
							default: ;
						endcase
					end
				end
				ST_INSERT: begin
					count_q   <= count_q + 1'b1;
					next_id_q <= next_id_q + 1'b1;
					strobe    <= 1'b1;
					state_q   <= ST_IDLE;
				end
				ST_REMOVE: begin
					// examine entry at wr_q; on a match the chain compacts, else advance
					if (step_q >= count_q) begin
						count_q <= wr_q;
						state_q <= ST_IDLE;
					end else begin
						step_q <= step_q + 1'b1;
						if (!ctl.compact)
							wr_q <= wr_q + 1'b1;
					end
				end
				ST_UPDATE: begin
					// stage 1: product of head entry; stage 2 below: accumulate
					pvalid_q <= (step_q < count_q);
					prod_q   <= head_src * routes[0].depth;
					bias_q   <= routes[0].bias;
					pmult_q  <= routes[0].mult;
					pen_q    <= routes[0].en;
					ptgt_q   <= routes[0].target;
					pfirst_q <= first_q;
					plast_q  <= (step_q + 1'b1 == count_q);
					pend_q   <= (step_q + 1'b1 == count_q) || routes[1].target != routes[0].target;
					first_q  <= (step_q + 1'b1 == count_q) || routes[1].target != routes[0].target;
					step_q   <= step_q + 1'b1;
					if (step_q == CntW'(MaxRoutes - 1))
						state_q <= ST_EMIT;
					if (pvalid_q) begin
						acc_q <= acc_next;
						if (pend_q) begin
							strobe <= 1'b1; kind <= 1'b1; status <= 1'b0; assigned_id <= '0;
							out_target <= ptgt_q; mod_value <= acc_next; last <= plast_q;
						end
					end
				end
				ST_EMIT: begin
					if (pvalid_q) begin
						acc_q <= acc_next;
						if (pend_q) begin
							strobe <= 1'b1; kind <= 1'b1; status <= 1'b0; assigned_id <= '0;
							out_target <= ptgt_q; mod_value <= acc_next; last <= plast_q;
						end
					end
					pvalid_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== test/mmc_checker.sv =====
// Checker: predicts and compares the results of the modulation matrix combiner.
module mmc_checker
	import mmc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  logic [1:0]             op,
	input  logic [TgtW-1:0]        route_target,
	input  logic [SrcW-1:0]        route_source,
	input  logic signed [ValW-1:0] route_depth,
	input  logic signed [ValW-1:0] route_bias,
	input  logic                   route_multiplies,
	input  logic                   route_enabled,
	input  logic                   bindings_present,
	input  logic [IdW-1:0]         remove_id,
	input  logic signed [ValW-1:0] source_sample,
	input  logic                   strobe,
	input  logic                   kind,
	input  logic                   status,
	input  logic [IdW-1:0]         assigned_id,
	input  logic [TgtW-1:0]        out_target,
	input  logic signed [AccW-1:0] mod_value,
	input  logic                   last,
	output int                     mismatches,
	output int                     pending,
	output int                     results_seen
);

	typedef struct {
		logic            kind;
		logic            status;
		logic [IdW-1:0]  id;
		logic [TgtW-1:0] target;
		logic [AccW-1:0] value;
		logic            last;
	} mod_result_t;

	route_t                 routes [MaxRoutes];
	int                     route_num;
	logic [IdW-1:0]         id_next;
	logic signed [ValW-1:0] sources [NumSources];
	mod_result_t            expected_results [$];

	assign pending = expected_results.size();

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	function automatic longint clamp24(input longint x);
		if (x > 8388607)
			return 8388607;
		if (x < -8388608)
			return -8388608;
		return x;
	endfunction

	task automatic push_result(input logic k, input logic s, input logic [IdW-1:0] id,
			input logic [TgtW-1:0] t, input longint v, input logic l);
		mod_result_t r;
		r.kind   = k;
		r.status = s;
		r.id     = id;
		r.target = t;
		r.value  = v[AccW-1:0];
		r.last   = l;
		expected_results = {expected_results, r};
	endtask

	task automatic predict_item();
		int     p;
		int     w;
		longint acc;
		longint sv;
		longint v;
		bit     first;
		case (op_t'(op))
			OP_ADD: begin
				if (!bindings_present || route_num >= MaxRoutes) begin
					push_result(1'b0, 1'b1, '0, '0, 0, 1'b0);
				end else begin
					p = route_num;
					for (int i = 0; i < route_num; i++)
						if (routes[i].target == route_target && p == route_num)
							p = i;
					for (int i = route_num; i > p; i--)
						routes[i] = routes[i-1];
					routes[p].id     = id_next;
					routes[p].target = route_target;
					routes[p].source = route_source;
					routes[p].depth  = route_depth;
					routes[p].bias   = route_bias;
					routes[p].mult   = route_multiplies;
					routes[p].en     = route_enabled;
					route_num++;
					push_result(1'b0, 1'b0, id_next, '0, 0, 1'b0);
					id_next++;
				end
			end
			OP_REMOVE: begin
				w = 0;
				for (int i = 0; i < route_num; i++)
					if (routes[i].id != remove_id) begin
						routes[w] = routes[i];
						w++;
					end
				route_num = w;
			end
			OP_SOURCE: begin
				if (route_source < NumSources)
					sources[route_source] = source_sample;
			end
			default: begin
				acc = 0;
				first = 1'b1;
				for (int i = 0; i < route_num; i++) begin
					sv = (routes[i].source < NumSources) ? longint'(sources[routes[i].source]) : 0;
					v = ((sv * longint'(routes[i].depth)) >>> 15) + longint'(routes[i].bias);
					if (first) begin
						acc = routes[i].mult ? 4096 : 0;
						first = 1'b0;
					end
					if (routes[i].en)
						acc = routes[i].mult ? clamp24((acc * v) >>> 12) : clamp24(acc + v);
					if (i + 1 == route_num || routes[i+1].target != routes[i].target) begin
						push_result(1'b1, 1'b0, '0, routes[i].target, acc, i + 1 == route_num);
						first = 1'b1;
					end
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		mod_result_t e;
		if (!arst_n) begin
			route_num = 0;
			id_next = '0;
			foreach (sources[i])
				sources[i] = '0;
			expected_results.delete();
			mismatches = 0;
			results_seen = 0;
		end else begin
			if (strobe) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report("unexpected result, kind", kind, 0);
				end else begin
					e = expected_results.pop_front();
					if (kind !== e.kind)
						report("kind", kind, e.kind);
					if (status !== e.status)
						report("status", status, e.status);
					if (assigned_id !== e.id)
						report("assigned_id", assigned_id, e.id);
					if (out_target !== e.target)
						report("out_target", out_target, e.target);
					if (mod_value !== e.value)
						report("mod_value", mod_value, e.value);
					if (last !== e.last)
						report("last", last, e.last);
				end
			end
			if (start && !busy)
				predict_item();
		end
	end

endmodule

// ===== test/tb.sv =====
// Testbench top: drives items into the modulation matrix combiner and gives the verdict.
module tb;
	import mmc_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [1:0]             op;
	logic [TgtW-1:0]        route_target;
	logic [SrcW-1:0]        route_source;
	logic signed [ValW-1:0] route_depth;
	logic signed [ValW-1:0] route_bias;
	logic                   route_multiplies;
	logic                   route_enabled;
	logic                   bindings_present;
	logic [IdW-1:0]         remove_id;
	logic signed [ValW-1:0] source_sample;
	logic                   strobe;
	logic                   kind;
	logic                   status;
	logic [IdW-1:0]         assigned_id;
	logic [TgtW-1:0]        out_target;
	logic signed [AccW-1:0] mod_value;
	logic                   last;

	int mismatches;
	int pending;
	int results_seen;
	int items_sent;
	int adds_sent;
	int quiet_cycles;

	localparam int QuietLimit = 2000;

	modulation_matrix_combiner_unit i_dut (.*);

	mmc_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("watchdog: no progress for %0d cycles", QuietLimit);
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'hFFFF;
			3: return 16'h1000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send(input op_t o, input logic [TgtW-1:0] t, input logic [SrcW-1:0] s,
			input logic [15:0] d, input logic [15:0] b, input logic m, input logic e,
			input logic bind_ok, input logic [IdW-1:0] rid, input logic [15:0] smp);
		bit ok;
		op               <= o;
		route_target     <= t;
		route_source     <= s;
		route_depth      <= d;
		route_bias       <= b;
		route_multiplies <= m;
		route_enabled    <= e;
		bindings_present <= bind_ok;
		remove_id        <= rid;
		source_sample    <= smp;
		start            <= 1'b1;
		do begin
			@(negedge clk);
			ok = !busy;
			@(posedge clk);
		end while (!ok);
		items_sent++;
		if (o == OP_ADD)
			adds_sent++;
	endtask

	task automatic add_route(input logic [TgtW-1:0] t, input logic [SrcW-1:0] s,
			input logic [15:0] d, input logic [15:0] b, input logic m, input logic e);
		send(OP_ADD, t, s, d, b, m, e, 1'b1, 16'($urandom), 16'($urandom));
	endtask

	task automatic pause(input bit allow);
		if (allow && $urandom_range(0, 99) < 28) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic random_item();
		int sel;
		logic [TgtW-1:0] t;
		sel = $urandom_range(0, 99);
		t = ($urandom_range(0, 3) == 0) ? TgtW'($urandom) : TgtW'($urandom_range(0, 5));
		if (sel < 32)
			send(OP_ADD, t, SrcW'($urandom), pick_value(), pick_value(), 1'($urandom),
				$urandom_range(0, 5) != 0, $urandom_range(0, 9) != 0,
				16'($urandom), 16'($urandom));
		else if (sel < 48)
			send(OP_REMOVE, t, SrcW'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
				1'($urandom), 1'($urandom),
				($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, adds_sent)),
				16'($urandom));
		else if (sel < 66)
			send(OP_SOURCE, t, SrcW'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
				1'($urandom), 1'($urandom), 16'($urandom), pick_value());
		else
			send(OP_UPDATE, t, SrcW'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
				1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_ADD;
		route_target = '0;
		route_source = '0;
		route_depth = '0;
		route_bias = '0;
		route_multiplies = 1'b0;
		route_enabled = 1'b0;
		bindings_present = 1'b0;
		remove_id = '0;
		source_sample = '0;
		quiet_cycles = 0;
		items_sent = 0;
		adds_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, unbound add, source extremes
		send(OP_UPDATE, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, '0, '0);
		send(OP_ADD, 6'd3, 4'd0, 16'h1000, 16'h0000, 1'b0, 1'b1, 1'b0, '0, '0);
		send(OP_SOURCE, '0, 4'd0, '0, '0, 1'b0, 1'b0, 1'b0, '0, 16'h7FFF);
		send(OP_SOURCE, '0, 4'd1, '0, '0, 1'b0, 1'b0, 1'b0, '0, 16'h8000);
		send(OP_SOURCE, '0, 4'd15, '0, '0, 1'b0, 1'b0, 1'b0, '0, 16'hFFFF);
		add_route(6'd5, 4'd0, 16'h7FFF, 16'h8000, 1'b0, 1'b1);
		send(OP_UPDATE, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, '0, '0);
		// disabled multiplicative entry in front of its group
		add_route(6'd5, 4'd1, 16'h8000, 16'h7FFF, 1'b1, 1'b0);
		add_route(6'd63, 4'd15, 16'h1000, 16'h0000, 1'b1, 1'b1);
		add_route(6'd0, 4'd2, 16'h7FFF, 16'h7FFF, 1'b0, 1'b1);
		send(OP_UPDATE, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, '0, '0);
		send(OP_REMOVE, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 16'd0, '0);
		send(OP_REMOVE, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 16'hFFFF, '0);
		send(OP_UPDATE, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, '0, '0);
		// fill to capacity with saturating products, then one add too many
		for (int i = 0; i < 14; i++)
			add_route(6'(i % 3 + 60), 4'(i % 2), 16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
		send(OP_UPDATE, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, '0, '0);
		send(OP_REMOVE, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 16'(adds_sent - 2), '0);
		send(OP_UPDATE, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, '0, '0);
		for (int i = 0; i < 16; i++)
			send(OP_REMOVE, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 16'(i), '0);

		for (int n = 0; n < 480; n++) begin
			random_item();
			pause(n < 200 || n >= 300);
		end
		start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		$display("sent %0d items (%0d adds), checked %0d results", items_sent, adds_sent,
			results_seen);
		$display("covered grouped inserts, removals, source writes and update passes");
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== modulation_matrix_combiner_unit.f =====
src/mmc_pkg.sv
src/mmc_cell.sv
src/mmc_chain.sv
src/modulation_matrix_combiner_unit.sv
test/mmc_checker.sv
test/tb.sv
